// ===== sv/ecpc_pkg.sv =====
// Shared types, constants and palette tables of the escape count colormap.
package ecpc_pkg;

    // Default number of fractional bits kept from the square root.
    localparam int FRACTION_BITS = 8;

    // Integer part of the scaled root is always below 640, so it fits ten bits.
    localparam int INT_W     = 10;
    // Conditional subtract steps of size << k, for k from MOD_STEPS-1 down to 0.
    localparam int MOD_STEPS = 7;
    localparam int IDX_W     = 4;
    localparam int SIZE_W    = 5;

    // Palette selector codes.
    localparam logic [1:0] SEL_SIXTEEN = 2'd0;
    localparam logic [1:0] SEL_TEN     = 2'd1;
    localparam logic [1:0] SEL_TWELVE  = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    localparam rgb_t PAL_A [16] = '{
        '{8'd15,  8'd30,  8'd66},  '{8'd26,  8'd7,   8'd25},
        '{8'd47,  8'd1,   8'd9},   '{8'd73,  8'd4,   8'd4},
        '{8'd100, 8'd7,   8'd0},   '{8'd138, 8'd44,  8'd12},
        '{8'd177, 8'd82,  8'd24},  '{8'd209, 8'd125, 8'd57},
        '{8'd229, 8'd181, 8'd134}, '{8'd248, 8'd236, 8'd211},
        '{8'd191, 8'd233, 8'd241}, '{8'd95,  8'd201, 8'd248},
        '{8'd0,   8'd170, 8'd255}, '{8'd0,   8'd128, 8'd204},
        '{8'd0,   8'd87,  8'd153}, '{8'd3,   8'd52,  8'd106}
    };

    localparam rgb_t PAL_B [10] = '{
        '{8'd60,  8'd0,   8'd20},  '{8'd130, 8'd10,  8'd60},
        '{8'd200, 8'd60,  8'd30},  '{8'd220, 8'd150, 8'd0},
        '{8'd160, 8'd220, 8'd20},  '{8'd80,  8'd240, 8'd100},
        '{8'd40,  8'd220, 8'd220}, '{8'd30,  8'd140, 8'd255},
        '{8'd80,  8'd50,  8'd230}, '{8'd140, 8'd20,  8'd140}
    };

    localparam rgb_t PAL_C [12] = '{
        '{8'd0,   8'd0,   8'd5},   '{8'd0,   8'd2,   8'd40},
        '{8'd0,   8'd10,  8'd90},  '{8'd0,   8'd25,  8'd150},
        '{8'd5,   8'd50,  8'd200}, '{8'd10,  8'd90,  8'd235},
        '{8'd15,  8'd140, 8'd255}, '{8'd40,  8'd190, 8'd255},
        '{8'd90,  8'd220, 8'd255}, '{8'd160, 8'd240, 8'd255},
        '{8'd220, 8'd250, 8'd255}, '{8'd255, 8'd255, 8'd255}
    };

    // Number of entries of the selected palette; the unused code means twelve.
    function automatic logic [SIZE_W-1:0] pal_size(input logic [1:0] sel);
        logic [SIZE_W-1:0] size;
        unique case (sel)
            SEL_SIXTEEN: size = 5'd16;
            SEL_TEN:     size = 5'd10;
            default:     size = 5'd12;
        endcase
        return size;
    endfunction

    // Entry of the selected palette; indexes past its end read as black.
    function automatic rgb_t pal_entry(input logic [1:0] sel, input logic [IDX_W-1:0] idx);
        rgb_t color;
        color = '0;
        unique case (sel)
            SEL_SIXTEEN: color = PAL_A[idx];
            SEL_TEN:     if (idx < 4'd10) color = PAL_B[idx];
            default:     if (idx < 4'd12) color = PAL_C[idx];
        endcase
        return color;
    endfunction

endpackage

// ===== sv/ecpc_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module ecpc_sqrt_cell #(
    parameter int XW = 32,
    parameter int RW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          enable,
    input  logic          in_valid,
    input  logic [XW-1:0] in_x,
    input  logic [RW+1:0] in_rem,
    input  logic [RW-1:0] in_root,
    output logic          out_valid,
    output logic [XW-1:0] out_x,
    output logic [RW+1:0] out_rem,
    output logic [RW-1:0] out_root
);

    localparam int RMW = RW + 2;

    logic          valid_reg;
    logic [XW-1:0] x_reg, x_next;
    logic [RMW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RMW-1:0] rem_cat;
    logic [RMW-1:0] trial;
    logic [RMW:0]   diff;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        rem_cat = {in_rem[RMW-3:0], in_x[XW-1:XW-2]};
        trial   = {in_root, 2'b01};
        diff    = {1'b0, rem_cat} - {1'b0, trial};
        x_next  = {in_x[XW-3:0], 2'b00};
        if (!diff[RMW]) begin
            rem_next  = diff[RMW-1:0];
            root_next = {in_root[RW-2:0], 1'b1};
        end else begin
            rem_next  = rem_cat;
            root_next = {in_root[RW-2:0], 1'b0};
        end
    end

    // The cell's word moves on whenever the chain advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
        if (enable) begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

// ===== sv/ecpc_lerp.sv =====
// Interpolation of one color channel between two palette entries.
module ecpc_lerp #(
    parameter int F = 8
) (
    input  logic [7:0]   a,
    input  logic [7:0]   b,
    input  logic [F-1:0] frac,
    input  logic         last,
    output logic [7:0]   value
);

    logic         up;
    logic [7:0]   mag;
    logic [F+7:0] prod;
    logic [7:0]   step;
    logic [8:0]   sum;

    // The step is truncated toward zero, so work on the magnitude.
    always_comb begin
        up    = (b >= a);
        mag   = up ? (b - a) : (a - b);
        prod  = {{F{1'b0}}, mag} * {8'd0, frac};
        step  = prod[F+7:F];
        sum   = {1'b0, a} + {1'b0, step};
        if (last) begin
            value = a;
        end else if (up) begin
            value = sum[8] ? 8'd255 : sum[7:0];
        end else begin
            value = (a < step) ? 8'd0 : (a - step);
        end
    end

endmodule

// ===== sv/escape_count_palette_colormap_unit.sv =====
// Top level: maps a Q16.16 escape count to an interpolated palette color.
// A word passes from input to output through one square root cell per root bit,
// then the palette reduction register and the interpolation into the output
// register. One word is accepted every cycle; the chain stalls only while the
// output word waits to be taken.
// Reset clears all valid flags and sets palette_select to the sixteen-entry palette.
module escape_count_palette_colormap_unit #(
    parameter int FRACTION_BITS = ecpc_pkg::FRACTION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // palette_select
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // iteration_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // blue [23:16], green [15:8], red [7:0]
);

    localparam int F   = FRACTION_BITS;
    localparam int SH  = 2 * F - 16;
    localparam int XW  = 16 + 2 * F;
    localparam int RW  = XW / 2;
    localparam int TW  = RW + 2;
    localparam int IW  = ecpc_pkg::INT_W;
    localparam int SW  = ecpc_pkg::SIZE_W;
    localparam int IXW = ecpc_pkg::IDX_W;

    logic advance;

    logic [1:0] sel_reg;

    logic          valid_s [RW+1];
    logic [XW-1:0] x_s     [RW+1];
    logic [RW+1:0] rem_s   [RW+1];
    logic [RW-1:0] root_s  [RW+1];

    logic [RW+2:0]  t5;
    logic [TW-1:0]  t;
    logic [SW-1:0]  size;
    logic [IW:0]    int_mod;
    logic           mod_valid_reg;
    logic [IXW-1:0] idx_reg, idx_next;
    logic [F-1:0]   frac_reg;

    ecpc_pkg::rgb_t lo_color, hi_color, mix_color;
    logic           last;
    logic           out_valid_reg;
    ecpc_pkg::rgb_t rgb_reg;

    // The whole pipeline moves unless a finished word is held at the output.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // Palette selection register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= ecpc_pkg::SEL_SIXTEEN;
        end else if (cfg_we) begin
            sel_reg <= cfg_wdata;
        end
    end

    // Align the Q16.16 count so its root carries F fractional bits.
    generate
        if (SH > 0) begin : g_shift_left
            assign x_s[0] = {s_tdata, {SH{1'b0}}};
        end else if (SH == 0) begin : g_no_shift
            assign x_s[0] = s_tdata;
        end else begin : g_shift_right
            assign x_s[0] = s_tdata[31:-SH];
        end
    endgenerate

    assign valid_s[0] = s_tvalid;
    assign rem_s[0]   = '0;
    assign root_s[0]  = '0;

    // Square root chain, one cell per result bit.
    generate
        for (genvar i = 0; i < RW; i++) begin : g_cell
            ecpc_sqrt_cell #(
                .XW(XW),
                .RW(RW)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .enable   (advance),
                .in_valid (valid_s[i]),
                .in_x     (x_s[i]),
                .in_rem   (rem_s[i]),
                .in_root  (root_s[i]),
                .out_valid(valid_s[i+1]),
                .out_x    (x_s[i+1]),
                .out_rem  (rem_s[i+1]),
                .out_root (root_s[i+1])
            );
        end
    endgenerate

    // Scale by 2.5 and reduce the integer part modulo the palette size.
    always_comb begin
        t5      = {1'b0, root_s[RW], 2'b00} + {3'b000, root_s[RW]};
        t       = t5[RW+2:1];
        size    = ecpc_pkg::pal_size(sel_reg);
        int_mod = {1'b0, t[TW-1:F]};
        for (int k = ecpc_pkg::MOD_STEPS - 1; k >= 0; k--) begin
            if (int_mod >= ((IW+1)'(size) << k)) begin
                int_mod = int_mod - ((IW+1)'(size) << k);
            end
        end
        idx_next = int_mod[IXW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_valid_reg <= 1'b0;
        end else if (advance) begin
            mod_valid_reg <= valid_s[RW];
        end
        if (advance) begin
            idx_reg  <= idx_next;
            frac_reg <= t[F-1:0];
        end
    end

    // Palette lookup and per-channel interpolation.
    always_comb begin
        lo_color = ecpc_pkg::pal_entry(sel_reg, idx_reg);
        hi_color = ecpc_pkg::pal_entry(sel_reg, idx_reg + 4'd1);
        last     = (idx_reg == IXW'(size - 5'd1));
    end

    ecpc_lerp #(.F(F)) u_lerp_red (
        .a    (lo_color.red),
        .b    (hi_color.red),
        .frac (frac_reg),
        .last (last),
        .value(mix_color.red)
    );

    ecpc_lerp #(.F(F)) u_lerp_green (
        .a    (lo_color.green),
        .b    (hi_color.green),
        .frac (frac_reg),
        .last (last),
        .value(mix_color.green)
    );

    ecpc_lerp #(.F(F)) u_lerp_blue (
        .a    (lo_color.blue),
        .b    (hi_color.blue),
        .frac (frac_reg),
        .last (last),
        .value(mix_color.blue)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= mod_valid_reg;
        end
        if (advance) begin
            rgb_reg <= mix_color;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rgb_reg;

endmodule
